// ----- rtl/line_and_fixed_frame_demux_assert.svh -----
`ifndef LINE_AND_FIXED_FRAME_DEMUX_ASSERT_SVH
`define LINE_AND_FIXED_FRAME_DEMUX_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LFFD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define LFFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/lffd_pkg.sv -----
package lffd_pkg;

    localparam int LINE_MAX  = 64;
    localparam int FRAME_LEN = 16;
    localparam int EMIT_MAX  = (LINE_MAX > FRAME_LEN) ? LINE_MAX : FRAME_LEN;

    localparam int LCNT_W  = $clog2(LINE_MAX + 1);
    localparam int FCNT_W  = $clog2(FRAME_LEN + 1);
    localparam int EMIT_W  = $clog2(EMIT_MAX + 1);
    localparam int LADDR_W = $clog2(LINE_MAX);
    localparam int FADDR_W = $clog2(FRAME_LEN);

    localparam logic [7:0] CH_J  = 8'h4A;
    localparam logic [7:0] CH_F  = 8'h46;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    localparam logic DEST_LINE  = 1'b0;
    localparam logic DEST_FRAME = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_SEND
    } t_state;

    typedef struct packed {
        logic load_byte;
        logic set_held;
        logic clr_held;
        logic line_push;
        logic push_j;
        logic frame_start;
        logic frame_push;
        logic line_emit;
        logic frame_emit;
        logic rd_en;
        logic emit_next;
    } t_dp_cmd;

    typedef struct packed {
        logic binary;
        logic held;
        logic is_j;
        logic is_f;
        logic is_lf;
        logic is_cr;
        logic line_empty;
        logic frame_done;
        logic emit_last;
    } t_dp_status;

endpackage

// ----- rtl/lffd_dpath.sv -----
`include "line_and_fixed_frame_demux_assert.svh"

module lffd_dpath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_byte,
    input  lffd_pkg::t_dp_cmd    i_cmd,
    output lffd_pkg::t_dp_status o_status,
    output logic                o_dest,
    output logic [7:0]          o_out_byte,
    output logic                o_last
);
    import lffd_pkg::*;

    logic [7:0]        r_byte;
    logic              r_held;
    logic              r_binary;
    logic [LCNT_W-1:0] r_line_cnt;
    logic [FCNT_W-1:0] r_frame_cnt;
    logic [EMIT_W-1:0] r_emit_len;
    logic [EMIT_W-1:0] r_k;
    logic              r_dest;
    logic [7:0]        r_line_rd;
    logic [7:0]        r_frame_rd;

    logic [7:0] r_line_mem  [LINE_MAX];
    logic [7:0] r_frame_mem [FRAME_LEN];

    logic line_full;
    logic emit_last;

    assign line_full = (r_line_cnt == LCNT_W'(LINE_MAX));
    assign emit_last = (r_k == r_emit_len - EMIT_W'(1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_byte) begin
            r_byte <= i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= 1'b0;
            r_binary    <= 1'b0;
            r_line_cnt  <= '0;
            r_frame_cnt <= '0;
            r_emit_len  <= '0;
            r_k         <= '0;
            r_dest      <= DEST_LINE;
        end else begin
            if (i_cmd.set_held) begin
                r_held <= 1'b1;
            end else if (i_cmd.clr_held) begin
                r_held <= 1'b0;
            end
            if (i_cmd.frame_start) begin
                r_binary    <= 1'b1;
                r_frame_cnt <= FCNT_W'(2);
            end else if (i_cmd.frame_push) begin
                if (o_status.frame_done) begin
                    r_frame_cnt <= '0;
                    r_binary    <= 1'b0;
                end else begin
                    r_frame_cnt <= r_frame_cnt + FCNT_W'(1);
                end
            end
            // a full store drops the byte and restarts the line
            if (i_cmd.line_push) begin
                r_line_cnt <= line_full ? '0 : r_line_cnt + LCNT_W'(1);
            end else if (i_cmd.line_emit) begin
                r_line_cnt <= '0;
            end
            if (i_cmd.line_emit) begin
                r_emit_len <= EMIT_W'(r_line_cnt);
                r_dest     <= DEST_LINE;
                r_k        <= '0;
            end else if (i_cmd.frame_emit) begin
                r_emit_len <= EMIT_W'(FRAME_LEN);
                r_dest     <= DEST_FRAME;
                r_k        <= '0;
            end else if (i_cmd.emit_next) begin
                r_k <= r_k + EMIT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.line_push && !line_full) begin
            r_line_mem[r_line_cnt[LADDR_W-1:0]] <= i_cmd.push_j ? CH_J : r_byte;
        end
        if (i_cmd.rd_en) begin
            r_line_rd <= r_line_mem[r_k[LADDR_W-1:0]];
        end
    end

    // the frame header is fixed, so entries 0 and 1 are never written
    always_ff @(posedge i_clk) begin
        if (i_cmd.frame_push) begin
            r_frame_mem[r_frame_cnt[FADDR_W-1:0]] <= r_byte;
        end
        if (i_cmd.rd_en) begin
            r_frame_rd <= r_frame_mem[r_k[FADDR_W-1:0]];
        end
    end

    always_comb begin
        o_status.binary     = r_binary;
        o_status.held       = r_held;
        o_status.is_j       = (r_byte == CH_J);
        o_status.is_f       = (r_byte == CH_F);
        o_status.is_lf      = (r_byte == CH_LF);
        o_status.is_cr      = (r_byte == CH_CR);
        o_status.line_empty = (r_line_cnt == '0);
        o_status.frame_done = (r_frame_cnt == FCNT_W'(FRAME_LEN - 1));
        o_status.emit_last  = emit_last;
    end

    always_comb begin
        if (r_dest == DEST_FRAME) begin
            if (r_k == EMIT_W'(0)) begin
                o_out_byte = CH_J;
            end else if (r_k == EMIT_W'(1)) begin
                o_out_byte = CH_F;
            end else begin
                o_out_byte = r_frame_rd;
            end
        end else begin
            o_out_byte = r_line_rd;
        end
    end

    assign o_dest = r_dest;
    assign o_last = emit_last;

    `LFFD_ASSERT_NOW(a_line_cnt_range, i_clk, i_rst_n, 1'b1, r_line_cnt <= LCNT_W'(LINE_MAX), "line count beyond store size")
    `LFFD_ASSERT_NOW(a_frame_cnt_range, i_clk, i_rst_n, r_binary, (r_frame_cnt >= FCNT_W'(2)) && (r_frame_cnt < FCNT_W'(FRAME_LEN)), "frame count out of range in binary mode")
    `LFFD_ASSERT_NOW(a_held_text_only, i_clk, i_rst_n, r_held, !r_binary, "held J while in binary mode")

endmodule

// ----- rtl/lffd_ctrl.sv -----
`include "line_and_fixed_frame_demux_assert.svh"

module lffd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  lffd_pkg::t_dp_status i_status,
    output lffd_pkg::t_dp_cmd    o_cmd
);
    import lffd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_byte = 1'b1;
                    n_state         = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_status.binary) begin
                    o_cmd.frame_push = 1'b1;
                    if (i_status.frame_done) begin
                        o_cmd.frame_emit = 1'b1;
                        n_state          = S_READ;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else if (i_status.held) begin
                    o_cmd.clr_held = 1'b1;
                    if (i_status.is_f) begin
                        o_cmd.frame_start = 1'b1;
                        n_state           = S_IDLE;
                    end else begin
                        // held J goes into the line, then the byte is decoded again
                        o_cmd.line_push = 1'b1;
                        o_cmd.push_j    = 1'b1;
                    end
                end else if (i_status.is_j) begin
                    o_cmd.set_held = 1'b1;
                    n_state        = S_IDLE;
                end else if (i_status.is_lf) begin
                    o_cmd.line_emit = 1'b1;
                    n_state         = i_status.line_empty ? S_IDLE : S_READ;
                end else if (i_status.is_cr) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.line_push = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_SEND;
            end
            S_SEND: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.emit_next = 1'b1;
                    n_state         = i_status.emit_last ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `LFFD_ASSERT_NEXT(a_accept_decodes, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == S_DECODE, "accepted byte not decoded")
    `LFFD_ASSERT_NOW(a_no_overlap, i_clk, i_rst_n, o_out_valid, !o_in_ready, "input taken while a result is pending")
    `LFFD_ASSERT_NOW(a_send_after_read, i_clk, i_rst_n, $rose(o_out_valid), $past(r_state) == S_READ, "result shown without a store read")
    `LFFD_ASSERT_NEXT(a_last_ends, i_clk, i_rst_n, o_out_valid && i_out_ready && i_status.emit_last, r_state == S_IDLE, "emission continues after last byte")

endmodule

// ----- rtl/line_and_fixed_frame_demux.sv -----
// flow: an accepted byte is registered, then decoded; when it completes a line or frame, the
// store is read and the first result byte is then shown, a pending held J being written to the
// line first; bytes that end nothing return to idle once decoded
// throughput: one byte at a time, as no input is taken while a line or frame is emitted; each
// emitted byte takes a store read into a register, then is held on the output until taken
// reset: synchronous active-low i_rst_n clears mode, held J and counters; stores not cleared
module line_and_fixed_frame_demux (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // [7:0] rx_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,  // [7:0] out_byte
    output logic       m_axis_tlast,  // last_byte
    output logic       m_axis_tuser   // [0] destination
);
    import lffd_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    lffd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    lffd_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte     (s_axis_tdata),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_dest     (m_axis_tuser),
        .o_out_byte (m_axis_tdata),
        .o_last     (m_axis_tlast)
    );

endmodule
